/* hw/rtl/totp_pkg.sv */
package totp_pkg;

    localparam int DEF_MAX_KEY_BYTES = 20;
    localparam int DEF_MAX_DRIFT     = 15;

    localparam logic [2:0] CFG_KEY_HIGH   = 3'd0;
    localparam logic [2:0] CFG_KEY_MIDDLE = 3'd1;
    localparam logic [2:0] CFG_KEY_LOW    = 3'd2;
    localparam logic [2:0] CFG_KEY_LEN    = 3'd3;
    localparam logic [2:0] CFG_DIGITS     = 3'd4;
    localparam logic [2:0] CFG_STEP       = 3'd5;

    localparam logic [1:0] STATUS_CURRENT = 2'd0;
    localparam logic [1:0] STATUS_WINDOW  = 2'd1;
    localparam logic [1:0] STATUS_NONE    = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_DIV    = 3'd2;
    localparam logic [2:0] OP_HMAC   = 3'd3;
    localparam logic [2:0] OP_MOD    = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] ctr_sel;   // 0 current, 1 minus, 2 plus
        logic [7:0] offset;
    } totp_cmd_t;

    typedef struct packed {
        logic done;
        logic match;
    } totp_sts_t;

    localparam logic [1:0] CTR_CUR   = 2'd0;
    localparam logic [1:0] CTR_MINUS = 2'd1;
    localparam logic [1:0] CTR_PLUS  = 2'd2;

    function automatic logic [31:0] sha1_k(input logic [6:0] r);
        if (r < 7'd20)      sha1_k = 32'h5A827999;
        else if (r < 7'd40) sha1_k = 32'h6ED9EBA1;
        else if (r < 7'd60) sha1_k = 32'h8F1BBCDC;
        else                sha1_k = 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] sha1_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20)      sha1_f = (b & c) | (~b & d);
        else if (r < 7'd40) sha1_f = b ^ c ^ d;
        else if (r < 7'd60) sha1_f = (b & c) | (b & d) | (c & d);
        else                sha1_f = b ^ c ^ d;
    endfunction

endpackage

/* hw/rtl/totp_sha1_core.sv */
module totp_sha1_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [159:0] h_in,
    input  logic [511:0] block,
    output logic         done,
    output logic [159:0] h_out
);
    import totp_pkg::*;

    logic [511:0] w_reg, w_next;
    logic [159:0] v_reg, v_next;
    logic [159:0] h_reg, h_next;
    logic [6:0]   round_reg, round_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;
    logic [31:0]  a, b, c, d, e, t, wn;

    assign a = v_reg[159:128];
    assign b = v_reg[127:96];
    assign c = v_reg[95:64];
    assign d = v_reg[63:32];
    assign e = v_reg[31:0];

    always_comb
    begin
        wn = w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480];
        wn = {wn[30:0], wn[31]};
        t  = {a[26:0], a[31:27]} + sha1_f(round_reg, b, c, d) + e + sha1_k(round_reg)
             + w_reg[511:480];
        w_next     = w_reg;
        v_next     = v_reg;
        h_next     = h_reg;
        round_next = round_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            w_next     = block;
            v_next     = h_in;
            h_next     = h_in;
            round_next = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            w_next = {w_reg[479:0], wn};
            v_next = {t, a, {b[1:0], b[31:2]}, c, d};
            if (round_reg == 7'd79)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                h_next = {h_reg[159:128] + t, h_reg[127:96] + a,
                          h_reg[95:64] + {b[1:0], b[31:2]},
                          h_reg[63:32] + c, h_reg[31:0] + d};
            end
            else
            begin
                round_next = round_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
        h_reg <= h_next;
    end

    assign done  = done_reg;
    assign h_out = h_reg;

endmodule

/* hw/rtl/totp_datapath.sv */
module totp_datapath #(
    parameter int MAX_KEY_BYTES = totp_pkg::DEF_MAX_KEY_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  totp_pkg::totp_cmd_t cmd,
    input  logic [63:0]         key_word_high,
    input  logic [63:0]         key_word_middle,
    input  logic [31:0]         key_word_low,
    input  logic [4:0]          key_length_bytes,
    input  logic [3:0]          code_digits,
    input  logic [15:0]         step_seconds,
    input  logic [39:0]         time_seconds,
    input  logic [29:0]         user_code,
    output totp_pkg::totp_sts_t sts,
    output logic [29:0]         code
);
    import totp_pkg::*;

    localparam int LIM = (MAX_KEY_BYTES < 20) ? MAX_KEY_BYTES : 20;
    localparam logic [4:0] LIM5 = 5'(LIM);

    logic [159:0] key_reg, key_next;
    logic [29:0]  user_reg;
    logic [29:0]  mod_reg, mod_next;
    // restoring divider
    logic [39:0]  quo_reg, quo_next;
    logic [16:0]  rem_reg, rem_next;
    logic [15:0]  div_reg, div_next;
    logic [63:0]  ctr_reg, ctr_next;
    logic [63:0]  hctr_reg, hctr_next;
    logic [5:0]   cnt_reg, cnt_next;
    // hmac sequencing: 0 ipad blk, 1 ctr blk, 2 opad blk, 3 final blk
    logic [2:0]   phase_reg, phase_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic         match_reg, match_next;
    logic [159:0] ih_reg, ih_next;
    logic [30:0]  bin_reg, bin_next;
    logic [29:0]  cur_reg, cur_next;

    logic         core_start;
    logic [159:0] core_hin;
    logic [511:0] core_blk;
    logic         core_done;
    logic [159:0] core_hout;
    logic [511:0] key_pad;
    logic [159:0] key_all;
    logic [159:0] mac;
    logic [3:0]   off;
    logic [31:0]  sel;
    logic [16:0]  rtry;

    localparam logic [159:0] H0 = 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;

    totp_sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .h_in  (core_hin),
        .block (core_blk),
        .done  (core_done),
        .h_out (core_hout)
    );

    always_comb
    begin
        key_pad = {key_reg, 352'd0};
        key_all = {key_word_high, key_word_middle, key_word_low};
        mac     = core_hout;
        off     = mac[3:0];
        sel     = mac[159 - 8*off -: 32];
        rtry    = {rem_reg[15:0], quo_reg[39]};
        key_next = key_reg; mod_next = mod_reg; quo_next = quo_reg; rem_next = rem_reg;
        div_next = div_reg; ctr_next = ctr_reg; hctr_next = hctr_reg; cnt_next = cnt_reg;
        phase_next = phase_reg; busy_next = busy_reg; done_next = 1'b0;
        match_next = match_reg; ih_next = ih_reg; bin_next = bin_reg;
        cur_next = cur_reg;
        core_start = 1'b0; core_hin = H0; core_blk = key_pad ^ {64{8'h36}};
        // while done is high the controller still shows the finished command
        case (done_reg ? OP_NONE : cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 20; i++)
                    key_next[159 - 8*i -: 8] = (5'(i) < key_length_bytes && 5'(i) < LIM5)
                        ? key_all[159 - 8*i -: 8]
                        : 8'h00;
                case (code_digits)
                    4'd0, 4'd1: mod_next = 30'd10;
                    4'd2:       mod_next = 30'd100;
                    4'd3:       mod_next = 30'd1000;
                    4'd4:       mod_next = 30'd10000;
                    4'd5:       mod_next = 30'd100000;
                    4'd6:       mod_next = 30'd1000000;
                    4'd7:       mod_next = 30'd10000000;
                    4'd8:       mod_next = 30'd100000000;
                    default:    mod_next = 30'd1000000000;
                endcase
                quo_next = time_seconds;
                rem_next = '0;
                div_next = (step_seconds == 16'd0) ? 16'd1 : step_seconds;
                cnt_next = '0;
                done_next = 1'b1;
            end
            OP_DIV:
            begin
                quo_next = {quo_reg[38:0], rtry >= {1'b0, div_reg}};
                rem_next = (rtry >= {1'b0, div_reg}) ? rtry - {1'b0, div_reg} : rtry;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd39)
                begin
                    done_next = 1'b1;
                    ctr_next = {24'd0, quo_next};
                end
            end
            OP_HMAC:
            begin
                if (!busy_reg)
                begin
                    case (cmd.ctr_sel)
                        CTR_MINUS: hctr_next = ctr_reg - {56'd0, cmd.offset};
                        CTR_PLUS:  hctr_next = ctr_reg + {56'd0, cmd.offset};
                        default:   hctr_next = ctr_reg;
                    endcase
                    busy_next = 1'b1;
                    phase_next = 3'd0;
                    core_start = 1'b1;
                end
                else if (core_done)
                begin
                    phase_next = phase_reg + 3'd1;
                    case (phase_reg)
                        3'd0:
                        begin
                            ih_next = core_hout;
                            core_start = 1'b1; core_hin = core_hout;
                            core_blk = {hctr_reg, 8'h80, 376'd0, 64'd576};
                        end
                        3'd1:
                        begin
                            ih_next = core_hout;
                            core_start = 1'b1; core_hin = H0;
                            core_blk = key_pad ^ {64{8'h5C}};
                        end
                        3'd2:
                        begin
                            core_start = 1'b1; core_hin = core_hout;
                            core_blk = {ih_reg, 8'h80, 280'd0, 64'd672};
                        end
                        default:
                        begin
                            bin_next = sel[30:0];
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            OP_MOD:
            begin
                // repeated subtraction by shifted modulus
                if (!busy_reg)
                begin
                    busy_next = 1'b1;
                    cnt_next = 6'd31;
                end
                else
                begin
                    if (({1'b0, bin_reg} >> cnt_reg[4:0]) >= {2'b0, mod_reg})
                        bin_next = bin_reg - 31'({1'b0, mod_reg} << cnt_reg[4:0]);
                    if (cnt_reg == 6'd0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        match_next = (bin_next[29:0] == user_reg);
                        if (cmd.ctr_sel == CTR_CUR && cmd.offset == 8'd0)
                            cur_next = bin_next[29:0];
                    end
                    else
                        cnt_next = cnt_reg - 6'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; phase_reg <= '0; cnt_reg <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; phase_reg <= phase_next;
            cnt_reg <= cnt_next; match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next; mod_reg <= mod_next; quo_reg <= quo_next; rem_reg <= rem_next;
        div_reg <= div_next; ctr_reg <= ctr_next; hctr_reg <= hctr_next; ih_reg <= ih_next;
        bin_reg <= bin_next; cur_reg <= cur_next;
        if (cmd.op == OP_LOAD)
            user_reg <= user_code;
    end

    assign sts.done  = done_reg;
    assign sts.match = match_reg;
    assign code      = cur_reg;

endmodule

/* hw/rtl/totp_ctrl.sv */
module totp_ctrl #(
    parameter int MAX_DRIFT = totp_pkg::DEF_MAX_DRIFT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [3:0]          drift_steps,
    input  totp_pkg::totp_sts_t sts,
    output totp_pkg::totp_cmd_t cmd,
    output logic                busy,
    output logic                result_valid,
    output logic [1:0]          match_status
);
    import totp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_HMAC = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [7:0] MAXD = 8'(MAX_DRIFT);

    logic [2:0] state_reg, state_next;
    logic [7:0] drift_reg, drift_next;
    logic [7:0] off_reg, off_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] din;

    always_comb
    begin
        din = {4'd0, drift_steps};
        state_next = state_reg; drift_next = drift_reg; off_next = off_reg;
        sel_next = sel_reg; status_next = status_reg;
        cmd.op = OP_NONE; cmd.ctr_sel = sel_reg; cmd.offset = off_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    // inputs are taken at the accepting edge
                    cmd.op = OP_LOAD;
                    drift_next = (din > MAXD) ? MAXD : din;
                    off_next = '0; sel_next = CTR_CUR; status_next = STATUS_NONE;
                    state_next = S_LOAD;
                end
            S_LOAD:
            begin
                if (sts.done) state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (sts.done) state_next = S_HMAC;
            end
            S_HMAC:
            begin
                cmd.op = OP_HMAC;
                if (sts.done) state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.op = OP_MOD;
                if (sts.done)
                begin
                    if (sts.match)
                        status_next = (sel_reg == CTR_CUR) ? STATUS_CURRENT : STATUS_WINDOW;
                    if (sts.match || (off_reg >= drift_reg && sel_reg != CTR_MINUS))
                        state_next = S_DONE;
                    else
                    begin
                        state_next = S_HMAC;
                        if (sel_reg == CTR_MINUS) sel_next = CTR_PLUS;
                        else
                        begin
                            sel_next = CTR_MINUS;
                            off_next = off_reg + 8'd1;
                        end
                    end
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; drift_reg <= '0; off_reg <= '0; sel_reg <= CTR_CUR;
            status_reg <= STATUS_NONE;
        end
        else
        begin
            state_reg <= state_next; drift_reg <= drift_next; off_reg <= off_next;
            sel_reg <= sel_next; status_reg <= status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign match_status = status_reg;

`ifndef SYNTHESIS
    a_done_from_mod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> $past(state_reg) == S_MOD) else $error("bad done");
    a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg <= drift_reg || state_reg == S_IDLE) else $error("offset past drift");
    a_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE) else $error("done not one cycle");
`endif

endmodule

/* hw/rtl/totp_code_check.sv */
// TOTP checker (HMAC-SHA1). Pulse start while busy is low; the result word appears
// on current_code/match_status for one cycle with result_valid, and must be taken
// then: the receiver cannot stall. A check runs the key load and step division,
// then per HMAC four 80-round SHA-1 blocks on one shared round unit plus a 32-step
// modulo, for up to 2*drift+1 HMACs. The user must write configuration only while
// busy is low; the block itself does not enforce it.
module totp_code_check #(
    parameter int MAX_KEY_BYTES = totp_pkg::DEF_MAX_KEY_BYTES,
    parameter int MAX_DRIFT     = totp_pkg::DEF_MAX_DRIFT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [39:0] time_seconds,
    input  logic [29:0] user_code,
    input  logic [3:0]  drift_steps,
    output logic        result_valid,
    output logic [29:0] current_code,
    output logic [1:0]  match_status
);
    import totp_pkg::*;

    logic [63:0] key_high_reg, key_mid_reg;
    logic [31:0] key_low_reg;
    logic [4:0]  key_len_reg;
    logic [3:0]  digits_reg;
    logic [15:0] step_reg;
    totp_cmd_t   cmd;
    totp_sts_t   sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0; key_mid_reg <= '0; key_low_reg <= '0;
            key_len_reg <= 5'd20; digits_reg <= 4'd6; step_reg <= 16'd30;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_HIGH:   key_high_reg <= cfg_data;
                CFG_KEY_MIDDLE: key_mid_reg  <= cfg_data;
                CFG_KEY_LOW:    key_low_reg  <= cfg_data[31:0];
                CFG_KEY_LEN:    key_len_reg  <= cfg_data[4:0];
                CFG_DIGITS:     digits_reg   <= cfg_data[3:0];
                CFG_STEP:       step_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    totp_ctrl #(.MAX_DRIFT(MAX_DRIFT)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .drift_steps(drift_steps),
        .sts(sts), .cmd(cmd), .busy(busy), .result_valid(result_valid),
        .match_status(match_status)
    );

    totp_datapath #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .key_word_high(key_high_reg), .key_word_middle(key_mid_reg),
        .key_word_low(key_low_reg), .key_length_bytes(key_len_reg),
        .code_digits(digits_reg), .step_seconds(step_reg),
        .time_seconds(time_seconds), .user_code(user_code),
        .sts(sts), .code(current_code)
    );

endmodule
